// File: rtl/core/pid_controller_step_top_assert.svh
// Assertion macros shared by the PID controller RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`define PID_CONTROLLER_STEP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcs: next-cycle check failed");

`endif

// File: rtl/core/pcs_pkg.sv
// Shared types, constants and width helpers for the PID controller.
// No dependencies; used by every module of the block but pcs_queue.
`default_nettype none

package pcs_pkg;

	// Default parameter values.
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF    = 4;

	// Fixed field widths.
	localparam int TARGET_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int DRIVE_W    = 32;
	localparam int SUM_W      = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic signed [DRIVE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DRIVE_W-1:0] S32_MIN = 32'sh8000_0000;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TARGET = 3'd0,
		CFG_PROP   = 3'd1,
		CFG_INTEG  = 3'd2,
		CFG_DERIV  = 3'd3,
		CFG_BIAS   = 3'd4,
		CFG_FLIP   = 3'd5
	} cfg_reg_t;

	// Item kinds carried on the input tuser.
	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// Control flags that travel with each queued item.
	typedef struct packed {
		logic clr;
		logic sum_clip;
	} pcs_tag_t;

	// Gain and bias settings seen by the back end.
	typedef struct packed {
		logic [GAIN_W-1:0]  prop;
		logic [GAIN_W-1:0]  integ;
		logic [GAIN_W-1:0]  deriv;
		logic [DRIVE_W-1:0] bias;
	} pcs_gains_t;

	// Width of the error: wide enough for the difference of sample and target.
	function automatic int err_width(input int sample_w);
		return ((sample_w > TARGET_W) ? sample_w : TARGET_W) + 1;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcs_front.sv
// Front end of the PID controller: accepts items, forms the error and keeps
// the loop state (saturating error sum, previous error). Depends on pcs_pkg.
`default_nettype none

module pcs_front #(
	parameter int SAMPLE_WIDTH = pcs_pkg::SAMPLE_WIDTH_DEF,
	localparam int ERR_W  = pcs_pkg::err_width(SAMPLE_WIDTH),
	localparam int DIFF_W = ERR_W + 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  in_op,
	input  logic signed [SAMPLE_WIDTH-1:0]        measured,
	input  logic signed [pcs_pkg::TARGET_W-1:0]   target_value,
	input  logic                                  flip_sign,
	output logic                                  push_valid,
	input  logic                                  push_ready,
	output pcs_pkg::pcs_tag_t                     push_tag,
	output logic signed [ERR_W-1:0]               push_err,
	output logic signed [DIFF_W-1:0]              push_diff,
	output logic signed [pcs_pkg::SUM_W-1:0]      push_sum
);

	localparam int SUM_RAW_W = ((ERR_W > pcs_pkg::SUM_W) ? ERR_W : pcs_pkg::SUM_W) + 1;

	logic signed [pcs_pkg::SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0]          last_error_q;

	logic signed [ERR_W-1:0]     meas_ext;
	logic signed [ERR_W-1:0]     tgt_ext;
	logic signed [ERR_W-1:0]     err_d;
	logic signed [SUM_RAW_W-1:0] sum_raw;
	logic                        sum_clip;
	logic signed [pcs_pkg::SUM_W-1:0] sum_d;
	logic                        is_clear;
	logic                        accept;

	assign is_clear   = (in_op == pcs_pkg::OP_CLEAR);
	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// Error and the saturating error sum.
	always_comb begin
		meas_ext = ERR_W'(measured);
		tgt_ext  = ERR_W'(target_value);
		err_d    = flip_sign ? (meas_ext - tgt_ext) : (tgt_ext - meas_ext);
		sum_raw  = SUM_RAW_W'(error_sum_q) + SUM_RAW_W'(err_d);
		sum_clip = !((&sum_raw[SUM_RAW_W-1:pcs_pkg::SUM_W-1]) ||
			(~|sum_raw[SUM_RAW_W-1:pcs_pkg::SUM_W-1]));
		if (sum_clip) begin
			sum_d = sum_raw[SUM_RAW_W-1] ? pcs_pkg::S32_MIN : pcs_pkg::S32_MAX;
		end else begin
			sum_d = sum_raw[pcs_pkg::SUM_W-1:0];
		end
	end

	// Record handed to the queue.
	always_comb begin
		push_tag.clr      = is_clear;
		push_tag.sum_clip = sum_clip && !is_clear;
		push_err          = err_d;
		push_diff         = DIFF_W'(err_d) - DIFF_W'(last_error_q);
		push_sum          = sum_d;
	end

	// Loop state is updated on each transfer; a clear item zeroes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (accept) begin
			if (is_clear) begin
				error_sum_q  <= '0;
				last_error_q <= '0;
			end else begin
				error_sum_q  <= sum_d;
				last_error_q <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/pcs_queue.sv
// Short first-in first-out queue between the front and back ends.
// Depends on the assertion macro header only.
`default_nettype none
`include "pid_controller_step_top_assert.svh"

module pcs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PCS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`PCS_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == CNT_W'($past(count_q) + 1'b1))
	`PCS_ASSERT_NEXT(a_count_down, clk, arst_n, pop && !push, count_q == CNT_W'($past(count_q) - 1'b1))

endmodule

`default_nettype wire

// File: rtl/core/pcs_back.sv
// Back end of the PID controller: three-stage pipeline of gain products,
// their sum, then scaling, bias and output saturation. Depends on pcs_pkg.
`default_nettype none
`include "pid_controller_step_top_assert.svh"

module pcs_back #(
	parameter int SAMPLE_WIDTH   = pcs_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pcs_pkg::GAIN_FRAC_BITS_DEF,
	localparam int ERR_W  = pcs_pkg::err_width(SAMPLE_WIDTH),
	localparam int DIFF_W = ERR_W + 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcs_pkg::pcs_gains_t                  gains,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  pcs_pkg::pcs_tag_t                    pop_tag,
	input  logic signed [ERR_W-1:0]              pop_err,
	input  logic signed [DIFF_W-1:0]             pop_diff,
	input  logic signed [pcs_pkg::SUM_W-1:0]     pop_sum,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [pcs_pkg::DRIVE_W-1:0]   drive,
	output logic                                 saturated
);

	localparam int PP_W = pcs_pkg::GAIN_W + ERR_W;
	localparam int PI_W = pcs_pkg::GAIN_W + pcs_pkg::SUM_W;
	localparam int PD_W = pcs_pkg::GAIN_W + DIFF_W;
	localparam int ACC_W = ((PD_W > PI_W) ? PD_W : PI_W) + 2;
	localparam int Y_W   = ACC_W + 1;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic advance1;
	logic advance2;
	logic advance3;

	logic signed [PP_W-1:0]  pp_s1;
	logic signed [PI_W-1:0]  pi_s1;
	logic signed [PD_W-1:0]  pd_s1;
	pcs_pkg::pcs_tag_t       tag_s1;
	logic signed [ACC_W-1:0] acc_s2;
	pcs_pkg::pcs_tag_t       tag_s2;
	logic signed [pcs_pkg::DRIVE_W-1:0] drive_s3;
	logic                    sat_s3;

	logic signed [Y_W-1:0]   y_d;
	logic                    y_clip;
	logic signed [pcs_pkg::DRIVE_W-1:0] drive_d;

	// A stage moves when it is empty or the stage after it moves.
	assign advance3  = !valid_s3 || out_ready;
	assign advance2  = !valid_s2 || advance3;
	assign advance1  = !valid_s1 || advance2;
	assign pop_ready = advance1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (advance1) begin
				valid_s1 <= pop_valid;
			end
			if (advance2) begin
				valid_s2 <= valid_s1;
			end
			if (advance3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: the three gain products.
	always_ff @(posedge clk) begin
		if (advance1) begin
			pp_s1  <= PP_W'($signed(gains.prop)) * PP_W'(pop_err);
			pi_s1  <= PI_W'($signed(gains.integ)) * PI_W'(pop_sum);
			pd_s1  <= PD_W'($signed(gains.deriv)) * PD_W'(pop_diff);
			tag_s1 <= pop_tag;
		end
	end

	// Stage 2: exact sum of the products.
	always_ff @(posedge clk) begin
		if (advance2) begin
			acc_s2 <= ACC_W'(pp_s1) + ACC_W'(pi_s1) + ACC_W'(pd_s1);
			tag_s2 <= tag_s1;
		end
	end

	// Scale by the gain fraction (floor), add the bias and clip to 32 bits.
	always_comb begin
		y_d    = Y_W'(acc_s2 >>> GAIN_FRAC_BITS) + Y_W'($signed(gains.bias));
		y_clip = !((&y_d[Y_W-1:pcs_pkg::DRIVE_W-1]) ||
			(~|y_d[Y_W-1:pcs_pkg::DRIVE_W-1]));
		if (y_clip) begin
			drive_d = y_d[Y_W-1] ? pcs_pkg::S32_MIN : pcs_pkg::S32_MAX;
		end else begin
			drive_d = y_d[pcs_pkg::DRIVE_W-1:0];
		end
	end

	// Stage 3: output register; a clear item reports zero.
	always_ff @(posedge clk) begin
		if (advance3) begin
			if (tag_s2.clr) begin
				drive_s3 <= '0;
				sat_s3   <= 1'b0;
			end else begin
				drive_s3 <= drive_d;
				sat_s3   <= y_clip || tag_s2.sum_clip;
			end
		end
	end

	assign out_valid = valid_s3;
	assign drive     = drive_s3;
	assign saturated = sat_s3;

	`PCS_ASSERT_NEXT(a_pop_loads_s1, clk, arst_n, pop_valid && pop_ready, valid_s1)
	`PCS_ASSERT_NEXT(a_s2_holds, clk, arst_n, valid_s2 && !advance2, valid_s2 && $stable(acc_s2))
	`PCS_ASSERT_NEXT(a_clear_zero, clk, arst_n, valid_s2 && tag_s2.clr && advance3, drive_s3 == '0 && !sat_s3)

endmodule

`default_nettype wire

// File: rtl/core/pid_controller_step_top.sv
// Discrete PID controller, top level. A result goes through the queue, then the
// product, sum and output registers of the back end, and is held while the output
// stalls. Throughput: one item per cycle while the output and queue do not stall;
// the error-sum update in the front end is the only loop. Reset clears the
// configuration registers, the error sum, the previous error, the queue and all
// valid flags at once. Depends on pcs_pkg, pcs_front, pcs_queue and pcs_back.
`default_nettype none

module pid_controller_step_top #(
	parameter int SAMPLE_WIDTH   = pcs_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = pcs_pkg::GAIN_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH    = pcs_pkg::QUEUE_DEPTH_DEF,
	localparam int IN_DATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_wr_en,
	input  logic [pcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_DATA_W-1:0]               s_tdata,  // [SAMPLE_WIDTH-1:0] measured
	input  logic                               s_tuser,  // [0] operation
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pcs_pkg::DRIVE_W-1:0]        m_tdata,  // [31:0] drive
	output logic                               m_tuser   // [0] saturated
);

	localparam int ERR_W  = pcs_pkg::err_width(SAMPLE_WIDTH);
	localparam int DIFF_W = ERR_W + 1;
	localparam int TAG_W  = $bits(pcs_pkg::pcs_tag_t);
	localparam int Q_W    = TAG_W + ERR_W + DIFF_W + pcs_pkg::SUM_W;

	logic signed [pcs_pkg::TARGET_W-1:0] target_q;
	logic [pcs_pkg::GAIN_W-1:0]          prop_q;
	logic [pcs_pkg::GAIN_W-1:0]          integ_q;
	logic [pcs_pkg::GAIN_W-1:0]          deriv_q;
	logic [pcs_pkg::DRIVE_W-1:0]         bias_q;
	logic                                flip_q;
	pcs_pkg::pcs_gains_t                 gains;

	logic                              push_valid;
	logic                              push_ready;
	pcs_pkg::pcs_tag_t                 push_tag;
	logic signed [ERR_W-1:0]           push_err;
	logic signed [DIFF_W-1:0]          push_diff;
	logic signed [pcs_pkg::SUM_W-1:0]  push_sum;
	logic [Q_W-1:0]                    push_data;

	logic                              pop_valid;
	logic                              pop_ready;
	logic [Q_W-1:0]                    pop_data;
	pcs_pkg::pcs_tag_t                 pop_tag;
	logic signed [ERR_W-1:0]           pop_err;
	logic signed [DIFF_W-1:0]          pop_diff;
	logic signed [pcs_pkg::SUM_W-1:0]  pop_sum;
	logic signed [pcs_pkg::DRIVE_W-1:0] drive;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			prop_q   <= '0;
			integ_q  <= '0;
			deriv_q  <= '0;
			bias_q   <= '0;
			flip_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pcs_pkg::CFG_TARGET: target_q <= cfg_data[pcs_pkg::TARGET_W-1:0];
				pcs_pkg::CFG_PROP:   prop_q   <= cfg_data[pcs_pkg::GAIN_W-1:0];
				pcs_pkg::CFG_INTEG:  integ_q  <= cfg_data[pcs_pkg::GAIN_W-1:0];
				pcs_pkg::CFG_DERIV:  deriv_q  <= cfg_data[pcs_pkg::GAIN_W-1:0];
				pcs_pkg::CFG_BIAS:   bias_q   <= cfg_data[pcs_pkg::DRIVE_W-1:0];
				pcs_pkg::CFG_FLIP:   flip_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		gains.prop  = prop_q;
		gains.integ = integ_q;
		gains.deriv = deriv_q;
		gains.bias  = bias_q;
	end

	pcs_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser),
		.measured     ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
		.target_value (target_q),
		.flip_sign    (flip_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_tag     (push_tag),
		.push_err     (push_err),
		.push_diff    (push_diff),
		.push_sum     (push_sum)
	);

	// Pack and unpack the queue record.
	assign push_data = {push_tag, push_err, push_diff, push_sum};
	assign pop_sum   = pop_data[pcs_pkg::SUM_W-1:0];
	assign pop_diff  = pop_data[pcs_pkg::SUM_W+DIFF_W-1:pcs_pkg::SUM_W];
	assign pop_err   = pop_data[pcs_pkg::SUM_W+DIFF_W+ERR_W-1:pcs_pkg::SUM_W+DIFF_W];
	assign pop_tag   = pop_data[Q_W-1:Q_W-TAG_W];

	pcs_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	pcs_back #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_tag   (pop_tag),
		.pop_err   (pop_err),
		.pop_diff  (pop_diff),
		.pop_sum   (pop_sum),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.drive     (drive),
		.saturated (m_tuser)
	);

	assign m_tdata = drive;

endmodule

`default_nettype wire
